FILE: hdl/bgd_pkg.sv
package bgd_pkg;

	// Button phase codes as reported on the result channel.
	typedef enum logic [1:0] {
		PH_RELEASED   = 2'd0,
		PH_PRESSED    = 2'd1,
		PH_DEBOUNCING = 2'd2
	} phase_t;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_BITS = 3;
	localparam int unsigned CFG_DATA_BITS = 16;

	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_SENSE_MODE      = 3'd0;
	localparam cfg_idx_t REG_ACTIVE_LEVEL    = 3'd1;
	localparam cfg_idx_t REG_TOUCH_THRESHOLD = 3'd2;
	localparam cfg_idx_t REG_DEBOUNCE_MS     = 3'd3;
	localparam cfg_idx_t REG_LONG_PRESS_MS   = 3'd4;
	localparam cfg_idx_t REG_DOUBLE_TAP_MS   = 3'd5;

	// Register reset values.
	localparam logic [15:0] RST_TOUCH_THRESHOLD = 16'd40;
	localparam logic [15:0] RST_DEBOUNCE_MS     = 16'd50;
	localparam logic [15:0] RST_LONG_PRESS_MS   = 16'd700;
	localparam logic [15:0] RST_DOUBLE_TAP_MS   = 16'd300;

endpackage

FILE: hdl/bgd_tick_if.sv
interface bgd_tick_if;
	logic        valid;
	logic        ready;
	logic        pin_level;
	logic [15:0] touch_value;

	modport source (output valid, pin_level, touch_value, input ready);
	modport sink (input valid, pin_level, touch_value, output ready);
endinterface

FILE: hdl/bgd_event_if.sv
interface bgd_event_if;
	logic            valid;
	logic            ready;
	bgd_pkg::phase_t phase;
	logic            click;
	logic            double_click;
	logic            long_press;
	logic            long_release;

	modport source (output valid, phase, click, double_click, long_press, long_release,
		input ready);
	modport sink (input valid, phase, click, double_click, long_press, long_release,
		output ready);
endinterface

FILE: hdl/button_gesture_debouncer.sv
// Channel   Role  Payload                                            Transfer when
// tick_in   sink  pin_level, touch_value                             valid && ready
// event_out src   phase, click, double_click, long_press, long_rel.  valid && ready
// cfg       wr    cfg_we, cfg_index, cfg_wdata                       cfg_we high
//
// Each tick is captured in an input register and evaluated combinationally by the
// gesture logic, whose result lands in the output register: one transfer per
// cycle sustained while the output is not stalled. The critical path runs through
// two chained TIME_BITS-wide subtractions and compares against 16-bit registers.
// Reset clears all control and timing state and loads the register defaults.
// A stall at the output holds the result and lets one more tick wait in the
// input register before tick_in.ready drops.
module button_gesture_debouncer #(
	parameter int unsigned TIME_BITS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  bgd_pkg::cfg_idx_t                  cfg_index,
	input  logic [bgd_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
	bgd_tick_if.sink                           tick_in,
	bgd_event_if.source                        event_out
);
	import bgd_pkg::*;

	typedef logic [TIME_BITS-1:0] time_t;

	// Configuration registers.
	logic        sense_mode_q;
	logic        active_level_q;
	logic [15:0] touch_threshold_q;
	logic [15:0] debounce_ms_q;
	logic [15:0] long_press_ms_q;
	logic [15:0] double_tap_ms_q;

	// Input register.
	logic        valid_s1;
	logic        pin_level_s1;
	logic [15:0] touch_value_s1;

	// Output register.
	logic        valid_s2;
	phase_t      phase_s2;
	logic        click_s2;
	logic        double_s2;
	logic        long_s2;
	logic        lrel_s2;

	// Gesture state.
	time_t  now_q;
	phase_t phase_q;
	time_t  debounce_start_q;
	time_t  press_start_q;
	time_t  tap_time_q;
	logic   held_q;
	logic   long_reported_q;
	logic   awaiting_q;
	logic   pending_q;

	logic advance;

	// The input stage moves on whenever the output register is free or is being
	// emptied in this cycle, so a result that is being taken does not stop new ticks.
	assign advance = valid_s1 && (!valid_s2 || event_out.ready);
	assign tick_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sense_mode_q      <= 1'b0;
			active_level_q    <= 1'b0;
			touch_threshold_q <= RST_TOUCH_THRESHOLD;
			debounce_ms_q     <= RST_DEBOUNCE_MS;
			long_press_ms_q   <= RST_LONG_PRESS_MS;
			double_tap_ms_q   <= RST_DOUBLE_TAP_MS;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SENSE_MODE:      sense_mode_q      <= cfg_wdata[0];
				REG_ACTIVE_LEVEL:    active_level_q    <= cfg_wdata[0];
				REG_TOUCH_THRESHOLD: touch_threshold_q <= cfg_wdata;
				REG_DEBOUNCE_MS:     debounce_ms_q     <= cfg_wdata;
				REG_LONG_PRESS_MS:   long_press_ms_q   <= cfg_wdata;
				REG_DOUBLE_TAP_MS:   double_tap_ms_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Gesture evaluation for the tick held in the input register.
	logic   level;
	logic   active;
	logic   accept;
	phase_t phase_a;
	phase_t phase_b;
	time_t  press_start_n;
	time_t  debounce_start_n;
	time_t  since_debounce;
	time_t  since_press;
	time_t  since_tap;
	logic   held_a;
	logic   long_rep_a;
	logic   release_ev;
	logic   lrel;
	logic   dbl;
	logic   tap_set;
	logic   held_b;
	logic   long_ev;
	logic   pending_a;
	logic   awaiting_a;
	logic   click_ev;

	always_comb begin
		if (sense_mode_q) begin
			level = (touch_value_s1 < touch_threshold_q);
		end else begin
			level = pin_level_s1;
		end
		active = (level == active_level_q);

		// Sensing: a pressed level opens a debounce window when released, anything else releases.
		if (active) begin
			phase_a = (phase_q == PH_RELEASED) ? PH_DEBOUNCING : phase_q;
		end else begin
			phase_a = PH_RELEASED;
		end
		debounce_start_n = (active && phase_q == PH_RELEASED) ? now_q : debounce_start_q;

		// A window opened in this very tick has zero elapsed time and never passes,
		// so only a window already running needs the compare.
		since_debounce = now_q - debounce_start_q;
		accept = active && (phase_q == PH_DEBOUNCING) &&
			(since_debounce > time_t'(debounce_ms_q));

		phase_b       = accept ? PH_PRESSED : phase_a;
		press_start_n = accept ? now_q : press_start_q;
		held_a        = accept || held_q || (phase_b == PH_PRESSED);
		long_rep_a    = accept ? 1'b0 : long_reported_q;

		since_press = now_q - press_start_n;

		// Release after a press: long release, second tap, or first tap.
		release_ev = held_a && (phase_b == PH_RELEASED);
		lrel       = release_ev && (since_press >= time_t'(long_press_ms_q));
		dbl        = release_ev && !lrel && awaiting_q;
		tap_set    = release_ev && !lrel && !awaiting_q;
		held_b     = held_a && !release_ev;

		awaiting_a = tap_set || (awaiting_q && !dbl);
		pending_a  = tap_set || (pending_q && !dbl);

		long_ev = held_b && !long_rep_a && (since_press > time_t'(long_press_ms_q));

		// A tap stamped in this tick has zero elapsed time and cannot time out yet.
		since_tap = now_q - tap_time_q;
		click_ev  = pending_a && !tap_set && (since_tap > time_t'(double_tap_ms_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1         <= 1'b0;
			valid_s2         <= 1'b0;
			now_q            <= '0;
			phase_q          <= PH_RELEASED;
			debounce_start_q <= '0;
			press_start_q    <= '0;
			tap_time_q       <= '0;
			held_q           <= 1'b0;
			long_reported_q  <= 1'b0;
			awaiting_q       <= 1'b0;
			pending_q        <= 1'b0;
		end else begin
			if (tick_in.valid && tick_in.ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end

			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (event_out.ready) begin
				valid_s2 <= 1'b0;
			end

			if (advance) begin
				now_q            <= now_q + time_t'(1);
				phase_q          <= phase_b;
				debounce_start_q <= debounce_start_n;
				press_start_q    <= press_start_n;
				if (tap_set) begin
					tap_time_q <= now_q;
				end
				held_q          <= held_b;
				long_reported_q <= long_rep_a || long_ev;
				awaiting_q      <= awaiting_a && !click_ev;
				pending_q       <= pending_a && !click_ev;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (tick_in.valid && tick_in.ready) begin
			pin_level_s1   <= tick_in.pin_level;
			touch_value_s1 <= tick_in.touch_value;
		end
		if (advance) begin
			phase_s2  <= phase_b;
			click_s2  <= click_ev;
			double_s2 <= dbl;
			long_s2   <= long_ev;
			lrel_s2   <= lrel;
		end
	end

	assign event_out.valid        = valid_s2;
	assign event_out.phase        = phase_s2;
	assign event_out.click        = click_s2;
	assign event_out.double_click = double_s2;
	assign event_out.long_press   = long_s2;
	assign event_out.long_release = lrel_s2;

	// A double click clears the pending single click in the same tick.
	a_double_not_click: assert property (@(posedge clk) disable iff (!arst_n)
		advance && dbl |-> !click_ev)
		else $error("double click and click in one tick");

	// A long press is only reported while the button is still down.
	a_long_while_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		advance && long_ev |-> phase_b == PH_PRESSED && !lrel)
		else $error("long press reported outside the pressed phase");

	// A long release only comes with the released phase.
	a_lrel_released: assert property (@(posedge clk) disable iff (!arst_n)
		advance && lrel |-> phase_b == PH_RELEASED)
		else $error("long release without release");

	// Every evaluated tick leaves a result in the output register.
	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("evaluated tick lost");

	// Held is only kept while the phase is pressed.
	a_held_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		held_q |-> phase_q == PH_PRESSED)
		else $error("held outside the pressed phase");

endmodule

FILE: tb/button_gesture_debouncer_tb.sv
`timescale 1ns / 1ps

module button_gesture_debouncer_tb;
	import bgd_pkg::*;

	localparam int CLK_HALF        = 5;
	localparam int RESET_CYCLES    = 9;
	// A long receiver hold-off. It lets the two-deep pipeline fill, so that tick_in.ready drops
	// while the sender keeps offering ticks.
	localparam int HOLD_OFF_CYCLES = 64;
	// The longest correct stretch without a transfer is the hold-off, plus a register update
	// and its drain. Random gaps at 80 % rarely run long. This limit is many times the
	// hold-off.
	localparam int STALL_LIMIT     = 1000;
	// Input register plus output register lie between transfer and result. Allow a margin.
	localparam int DRAIN_CYCLES    = 8;

	// Indexes beyond the register file. Writes to them must change nothing.
	localparam cfg_idx_t REG_SPARE_A = 3'd6;
	localparam cfg_idx_t REG_SPARE_B = 3'd7;

	typedef struct packed {
		phase_t phase;
		logic   click;
		logic   double_click;
		logic   long_press;
		logic   long_release;
	} gesture_t;

	// Tracks the gesture state machine tick by tick. It also holds the results still owed by
	// the block.
	class gesture_tracker;
		logic        cap_mode;
		logic        active_lvl;
		logic [15:0] threshold;
		logic [15:0] debounce_len;
		logic [15:0] long_len;
		logic [15:0] tap_window;
		logic [31:0] now_t;
		logic [31:0] bounce_mark;
		logic [31:0] press_mark;
		logic [31:0] tap_mark;
		phase_t      state_ph;
		logic        held;
		logic        long_done;
		logic        second_due;
		logic        click_due;
		gesture_t    awaited[$];
		int          errors;

		function new();
			cap_mode     = 1'b0;
			active_lvl   = 1'b0;
			threshold    = RST_TOUCH_THRESHOLD;
			debounce_len = RST_DEBOUNCE_MS;
			long_len     = RST_LONG_PRESS_MS;
			tap_window   = RST_DOUBLE_TAP_MS;
			now_t        = '0;
			bounce_mark  = '0;
			press_mark   = '0;
			tap_mark     = '0;
			state_ph     = PH_RELEASED;
			held         = 1'b0;
			long_done    = 1'b0;
			second_due   = 1'b0;
			click_due    = 1'b0;
			errors       = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [15:0] data);
			case (idx)
				REG_SENSE_MODE:      cap_mode = data[0];
				REG_ACTIVE_LEVEL:    active_lvl = data[0];
				REG_TOUCH_THRESHOLD: threshold = data;
				REG_DEBOUNCE_MS:     debounce_len = data;
				REG_LONG_PRESS_MS:   long_len = data;
				REG_DOUBLE_TAP_MS:   tap_window = data;
				default: ;
			endcase
		endfunction

		// Elapsed time since a mark. It wraps at 32 bits, as the block's counter does.
		function logic [31:0] since(logic [31:0] mark);
			return now_t - mark;
		endfunction

		function void take_tick(logic pin, logic [15:0] touch);
			gesture_t want;
			logic     level;
			want = '0;
			level = cap_mode ? (touch < threshold) : pin;
			if (level == active_lvl) begin
				if (state_ph == PH_RELEASED) begin
					bounce_mark = now_t;
					state_ph = PH_DEBOUNCING;
				end
			end else begin
				state_ph = PH_RELEASED;
			end
			if (state_ph == PH_DEBOUNCING && since(bounce_mark) > debounce_len) begin
				state_ph = PH_PRESSED;
				press_mark = now_t;
				held = 1'b1;
				long_done = 1'b0;
			end
			if (!held && state_ph == PH_PRESSED)
				held = 1'b1;
			if (held && state_ph == PH_RELEASED) begin
				if (since(press_mark) >= long_len) begin
					want.long_release = 1'b1;
				end else if (second_due) begin
					want.double_click = 1'b1;
					second_due = 1'b0;
					click_due = 1'b0;
				end else begin
					second_due = 1'b1;
					click_due = 1'b1;
					tap_mark = now_t;
				end
				held = 1'b0;
			end
			if (held && since(press_mark) > long_len && !long_done) begin
				want.long_press = 1'b1;
				long_done = 1'b1;
			end
			if (click_due && since(tap_mark) > tap_window) begin
				want.click = 1'b1;
				click_due = 1'b0;
				second_due = 1'b0;
			end
			want.phase = state_ph;
			now_t = now_t + 32'd1;
			awaited.push_back(want);
		endfunction

		function void compare_field(string name, logic [1:0] want_v, logic [1:0] got_v);
			if (got_v !== want_v) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
			end
		endfunction

		function void check_result(gesture_t got);
			gesture_t want;
			if (awaited.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, got phase %0d flags %b%b%b%b",
					$time, got.phase, got.click, got.double_click, got.long_press,
					got.long_release);
				return;
			end
			want = awaited.pop_front();
			compare_field("phase", want.phase, got.phase);
			compare_field("click", {1'b0, want.click}, {1'b0, got.click});
			compare_field("double_click", {1'b0, want.double_click},
				{1'b0, got.double_click});
			compare_field("long_press", {1'b0, want.long_press}, {1'b0, got.long_press});
			compare_field("long_release", {1'b0, want.long_release},
				{1'b0, got.long_release});
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	cfg_idx_t                 cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_wdata;

	bgd_tick_if  tick_bus ();
	bgd_event_if event_bus ();

	gesture_tracker tracker;

	// Idling controls. Both percentages, changed by the stimulus between phases, apply per cycle.
	int src_idle_pct;
	int sink_stall_pct;
	bit hold_off_req;

	button_gesture_debouncer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.tick_in   (tick_bus),
		.event_out (event_bus)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// One register write. The enable stays high, so back-to-back writes never lower and raise
	// it in the same step. The caller drops it after the last write.
	task automatic poke_reg(input cfg_idx_t idx, input logic [15:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		tracker.write_reg(idx, data);
	endtask

	// Writes the whole register file. Random junk goes above the one-bit registers. Random
	// writes also go to both unused indexes, which the block must ignore.
	task automatic apply_setting(input logic cap, act, input logic [15:0] thr, deb, lp, dt);
		logic [14:0] junk;
		junk = 15'($urandom);
		poke_reg(REG_SENSE_MODE, {junk, cap});
		junk = 15'($urandom);
		poke_reg(REG_ACTIVE_LEVEL, {junk, act});
		poke_reg(REG_TOUCH_THRESHOLD, thr);
		poke_reg(REG_DEBOUNCE_MS, deb);
		poke_reg(REG_LONG_PRESS_MS, lp);
		poke_reg(REG_DOUBLE_TAP_MS, dt);
		poke_reg(REG_SPARE_A, 16'($urandom));
		poke_reg(REG_SPARE_B, 16'($urandom));
		cfg_we <= 1'b0;
	endtask

	// Offers one tick, after a random number of idle cycles. Valid stays high after the
	// transfer. It is lowered only by the next idle cycle or by settle, and never twice in one
	// step.
	task automatic send_tick(input logic pin, input logic [15:0] touch);
		while ($urandom_range(99) < src_idle_pct) begin
			tick_bus.valid <= 1'b0;
			@(posedge clk);
		end
		tick_bus.valid       <= 1'b1;
		tick_bus.pin_level   <= pin;
		tick_bus.touch_value <= touch;
		@(posedge clk);
		while (tick_bus.ready !== 1'b1)
			@(posedge clk);
		tracker.take_tick(pin, touch);
	endtask

	// Sends one tick whose sensed level is pressed or released under the current settings.
	// The field that the sense mode ignores gets random content.
	task automatic send_level(input logic pressed);
		logic        sensed;
		logic        pin;
		logic [15:0] touch;
		sensed = pressed ? tracker.active_lvl : ~tracker.active_lvl;
		pin    = 1'($urandom_range(1));
		touch  = 16'($urandom);
		if (!tracker.cap_mode)
			pin = sensed;
		else if (sensed && tracker.threshold != 16'd0)
			touch = 16'($urandom_range(tracker.threshold - 16'd1));
		else if (!sensed)
			touch = 16'($urandom_range(16'hFFFF, tracker.threshold));
		send_tick(pin, touch);
	endtask

	// Drops valid and waits for every owed result. Then it waits out the pipeline, so that a
	// register write cannot overtake a tick.
	task automatic settle();
		tick_bus.valid <= 1'b0;
		while (tracker.awaited.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One random phase. Most of the traffic is well-formed presses. Each press is sized against
	// the current debounce, long-press and double-tap times. Taps, exact-length holds, long
	// holds, bounces and double taps all turn up. The rest is noise with random fields. Large
	// register values are clamped here, so that the phase stays short.
	task automatic run_phase(input int idle_pct, input int stall_pct, input int n_ticks,
		input bit hold_midway);
		int sent;
		int deb_c;
		int lp_c;
		int dt_c;
		int hold;
		int gap;
		src_idle_pct   = idle_pct;
		sink_stall_pct = stall_pct;
		sent  = 0;
		deb_c = tracker.debounce_len > 16'd12 ? 12 : tracker.debounce_len;
		lp_c  = tracker.long_len > 16'd40 ? 40 : tracker.long_len;
		dt_c  = tracker.tap_window > 16'd20 ? 20 : tracker.tap_window;
		while (sent < n_ticks) begin
			if (hold_midway && sent >= n_ticks / 2) begin
				hold_off_req = 1'b1;
				hold_midway  = 1'b0;
			end
			if ($urandom_range(99) < 80) begin
				// Now and then a bounce that ends before the debounce time.
				if ($urandom_range(9) == 0)
					hold = $urandom_range(deb_c + 1, 1);
				else
					hold = deb_c + 1 + $urandom_range(lp_c + 2);
				gap = $urandom_range(dt_c + 3, 1);
				repeat (hold) send_level(1'b1);
				repeat (gap) send_level(1'b0);
				sent += hold + gap;
			end else begin
				gap = $urandom_range(4, 1);
				repeat (gap) send_tick(1'($urandom_range(1)), 16'($urandom));
				sent += gap;
			end
		end
		settle();
	endtask

	// Result side. It takes every transfer to the scoreboard. It drives ready at random, except
	// during a hold-off, which is counted here and not in the stimulus process.
	initial begin
		int       hold_left;
		gesture_t got;
		hold_left = 0;
		event_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (event_bus.valid && event_bus.ready) begin
				got.phase        = event_bus.phase;
				got.click        = event_bus.click;
				got.double_click = event_bus.double_click;
				got.long_press   = event_bus.long_press;
				got.long_release = event_bus.long_release;
				tracker.check_result(got);
			end
			if (hold_left > 0) begin
				hold_left--;
				event_bus.ready <= 1'b0;
			end else if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left = HOLD_OFF_CYCLES;
				event_bus.ready <= 1'b0;
			end else begin
				event_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	// Watchdog. It ends the run when no transfer happens on either channel for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((tick_bus.valid && tick_bus.ready) || (event_bus.valid && event_bus.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		string directed;
		tracker = new();
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = REG_SENSE_MODE;
		cfg_wdata            = '0;
		tick_bus.valid       = 1'b0;
		tick_bus.pin_level   = 1'b0;
		tick_bus.touch_value = '0;
		src_idle_pct         = 0;
		sink_stall_pct       = 0;
		hold_off_req         = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed gestures, digital pin active high, zero debounce. Each press is accepted on
		// the tick after it is first sensed. The sequence is as follows:
		// - a tap, then a second tap inside the window, which gives a double click;
		// - a hold of exactly the long-press time, which gives a long release with no long press;
		// - a longer hold, which gives both;
		// - a lone tap, left to time out into a single click.
		apply_setting(1'b0, 1'b1, 16'd40, 16'd0, 16'd3, 16'd4);
		directed = "110110111101111110110000000";
		for (int i = 0; i < directed.len(); i++)
			send_level(directed.getc(i) == "1");
		settle();

		// The capacitive extremes. With a threshold of one, a reading of zero is touched and
		// full scale is not. The pin level is ignored.
		apply_setting(1'b1, 1'b1, 16'd1, 16'd0, 16'd3, 16'd4);
		send_tick(1'b0, 16'h0000);
		send_tick(1'b1, 16'hFFFF);
		send_tick(1'b1, 16'h0000);
		send_tick(1'b0, 16'hFFFF);
		settle();

		// The smallest times, with no idling. Halfway through, the receiver holds off, so that
		// the block backs up into the sender.
		apply_setting(1'b0, 1'b1, 16'd40, 16'd0, 16'd1, 16'd1);
		run_phase(0, 0, 100, 1'b1);

		// Capacitive sensing at mid threshold. The sender idles most of the time.
		apply_setting(1'b1, 1'b1, 16'h8000, 16'd2, 16'd8, 16'd5);
		run_phase(80, 0, 80, 1'b0);

		// Digital sensing, active low. The receiver stalls most of the time.
		apply_setting(1'b0, 1'b0, 16'hFFFF, 16'd1, 16'd6, 16'd4);
		run_phase(0, 80, 100, 1'b0);

		// Capacitive, active low, at full-scale threshold: only a full-scale reading counts as
		// pressed. Both sides idle now and then.
		apply_setting(1'b1, 1'b0, 16'hFFFF, 16'd3, 16'd12, 16'd8);
		run_phase(34, 34, 100, 1'b0);

		// Every time at its maximum and the threshold at zero. Presses never get past
		// debouncing.
		apply_setting(1'b0, 1'b0, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		run_phase(0, 0, 40, 1'b0);

		// Medium times under capacitive sensing, with both sides idling.
		apply_setting(1'b1, 1'b1, 16'd1000, 16'd5, 16'd20, 16'd10);
		run_phase(34, 34, 80, 1'b0);

		if (tracker.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
